// ===== rtl/mpa_pkg.sv =====
// shared types and constants for the max pooling argmax block
package mpa_pkg;

  // field widths fixed by the register map and the result format
  localparam int POOL_W     = 4;
  localparam int STRIDE_W   = 4;
  localparam int LEN_W      = 13;
  localparam int POS_W      = 13;
  localparam int IDX_W      = 12;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_POOL_SIZE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STRIDE     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_LENGTH = 2'd2;

  // register reset values
  localparam logic [POOL_W-1:0]   RST_POOL_SIZE  = 4'd2;
  localparam logic [STRIDE_W-1:0] RST_STRIDE     = 4'd2;
  localparam logic [LEN_W-1:0]    RST_ROW_LENGTH = 13'd16;

  // effective (clamped) configuration
  typedef struct packed {
    logic [POOL_W-1:0]   pool;
    logic [STRIDE_W-1:0] stride;
    logic [LEN_W-1:0]    len;
  } cfg_t;

  // where the current sample sits in its row
  typedef struct packed {
    logic [POS_W-1:0]    pos;    // position in the row
    logic [STRIDE_W-1:0] phase;  // pos mod stride
    logic [POS_W-1:0]    khi;    // pos div stride, newest window started
  } pos_t;

endpackage

// ===== rtl/mpa_ifs.sv =====
// handshake channels of the max pooling argmax block

// sample input channel
interface mpa_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// window result channel
interface mpa_out_if import mpa_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic [IDX_W-1:0]              max_position;
  logic [IDX_W-1:0]              window_index;
  logic                          last_window;

  modport source (output valid, output max_value, output max_position,
                  output window_index, output last_window, input ready);
  modport sink   (input valid, input max_value, input max_position,
                  input window_index, input last_window, output ready);
endinterface

// register write channel
interface mpa_cfg_if import mpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mpa_cfg.sv =====
// configuration registers and their clamped effective values
module mpa_cfg import mpa_pkg::*; #(
  parameter int POOL_MAX = 8,
  parameter int ROW_MAX  = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  logic [CFG_ADDR_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  eff,
  output logic                  restart
);

  logic [POOL_W-1:0]   win_size;
  logic [STRIDE_W-1:0] stride;
  logic [LEN_W-1:0]    row_length;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      win_size   <= RST_POOL_SIZE;
      stride     <= RST_STRIDE;
      row_length <= RST_ROW_LENGTH;
    end else if (wr) begin
      case (wr_index)
        CFG_POOL_SIZE:  win_size   <= wr_data[POOL_W-1:0];
        CFG_STRIDE:     stride     <= wr_data[STRIDE_W-1:0];
        CFG_ROW_LENGTH: row_length <= wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // any write to a known register restarts the row
  always_comb begin
    case (wr_index)
      CFG_POOL_SIZE, CFG_STRIDE, CFG_ROW_LENGTH: restart = wr;
      default:                                   restart = 1'b0;
    endcase
  end

  // zero acts as one; oversize pool size and row length clamp to their maximums
  always_comb begin
    if (win_size == '0) eff.pool = POOL_W'(1);
    else if (32'(win_size) > POOL_MAX) eff.pool = POOL_W'(POOL_MAX);
    else eff.pool = win_size;

    if (stride == '0) eff.stride = STRIDE_W'(1);
    else eff.stride = stride;

    if (row_length == '0) eff.len = LEN_W'(1);
    else if (32'(row_length) > ROW_MAX) eff.len = LEN_W'(ROW_MAX);
    else eff.len = row_length;
  end

endmodule

// ===== rtl/mpa_pos.sv =====
// row position tracking: position, phase within stride, window counters
module mpa_pos import mpa_pkg::*; #(
  parameter int POOL_MAX = 8,
  localparam int SW = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  logic          step,
  input  cfg_t          cfg,
  output pos_t          pos,
  output logic [SW-1:0] khi_slot
);

  logic row_end;
  logic phase_wrap;

  assign row_end    = (POS_W+1)'(pos.pos) + (POS_W+1)'(1) >= (POS_W+1)'(cfg.len);
  assign phase_wrap = pos.phase + STRIDE_W'(1) == cfg.stride;

  // advance one sample, wrap at row end
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos      <= '0;
      khi_slot <= '0;
    end else if (step) begin
      if (row_end) begin
        pos      <= '0;
        khi_slot <= '0;
      end else begin
        pos.pos <= pos.pos + POS_W'(1);
        if (phase_wrap) begin
          pos.phase <= '0;
          pos.khi   <= pos.khi + POS_W'(1);
          if (khi_slot == SW'(POOL_MAX - 1)) khi_slot <= '0;
          else khi_slot <= khi_slot + SW'(1);
        end else begin
          pos.phase <= pos.phase + STRIDE_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/mpa_slots.sv =====
// open window slots: parallel compare and update, closing window select
module mpa_slots import mpa_pkg::*; #(
  parameter int POOL_MAX    = 8,
  parameter int SAMPLE_BITS = 16,
  localparam int SW = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1,
  localparam int JW = SW + 1,
  localparam int PW = SW + STRIDE_W + 2
) (
  input  logic                          clk,
  input  logic                          step,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  cfg_t                          cfg,
  input  pos_t                          pos,
  input  logic [SW-1:0]                 khi_slot,
  output logic                          emit,
  output logic signed [SAMPLE_BITS-1:0] max_value,
  output logic [IDX_W-1:0]              max_position,
  output logic [IDX_W-1:0]              window_index,
  output logic                          last_window
);

  logic signed [SAMPLE_BITS-1:0] slot_max [POOL_MAX];
  logic [POS_W-1:0]              slot_pos [POOL_MAX];

  logic [JW-1:0]                 age   [POOL_MAX];
  logic [PW-1:0]                 reach [POOL_MAX];
  logic [POOL_MAX-1:0]           live;
  logic [POOL_MAX-1:0]           take;
  logic [POOL_MAX-1:0]           ends;
  logic signed [SAMPLE_BITS-1:0] new_max [POOL_MAX];
  logic [POS_W-1:0]              new_pos [POOL_MAX];
  logic signed [SAMPLE_BITS-1:0] sel_max;
  logic [POS_W-1:0]              sel_pos;
  logic [JW-1:0]                 sel_age;

  // per slot: how many windows back it is, whether it holds p, whether it closes
  always_comb begin
    sel_max = '0;
    sel_pos = '0;
    sel_age = '0;
    for (int i = 0; i < POOL_MAX; i++) begin
      if (khi_slot >= SW'(i)) age[i] = JW'(khi_slot) - JW'(i);
      else age[i] = JW'(khi_slot) + JW'(POOL_MAX - i);
      reach[i] = PW'(pos.phase) + PW'(age[i]) * PW'(cfg.stride);
      live[i]  = (POS_W'(age[i]) <= pos.khi) && (reach[i] < PW'(cfg.pool));
      take[i]  = live[i] && (((age[i] == '0) && (pos.phase == '0)) ||
                             (sample > slot_max[i]));
      new_max[i] = take[i] ? sample : slot_max[i];
      new_pos[i] = take[i] ? pos.pos : slot_pos[i];
      ends[i]  = live[i] && (reach[i] == PW'(cfg.pool - POOL_W'(1)));
      // at most one slot closes, so an and-or select is enough
      sel_max = sel_max | (new_max[i] & {SAMPLE_BITS{ends[i]}});
      sel_pos = sel_pos | (new_pos[i] & {POS_W{ends[i]}});
      sel_age = sel_age | (age[i] & {JW{ends[i]}});
    end
  end

  // slot storage update
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < POOL_MAX; i++) begin
        slot_max[i] <= new_max[i];
        slot_pos[i] <= new_pos[i];
      end
    end
  end

  // closing window result; last when the next window would run past the row
  assign emit         = (|ends) && ({1'b0, cfg.len} >= (LEN_W+1)'(cfg.pool));
  assign max_value    = sel_max;
  assign max_position = sel_pos[IDX_W-1:0];
  assign window_index = IDX_W'(pos.khi - POS_W'(sel_age));
  assign last_window  = (POS_W+1)'(pos.pos) + (POS_W+1)'(cfg.stride) >=
                        (POS_W+1)'(cfg.len);

endmodule

// ===== rtl/max_pool_1d_argmax_top.sv =====
// top level of the streaming 1-d max pooling block with argmax
//
//  channel  dir  payload                                              handshake
//  in_ch    in   sample                                               valid/ready
//  out_ch   out  max_value, max_position, window_index, last_window   valid/ready
//  cfg_ch   in   index, data                                          valid/ready
//
//  one sample per cycle sustained while the result channel is not stalled; a result
//  passes from the input register through the single slot compare stage into the result register
//  reset (rst, synchronous) restores the register defaults and clears row
//  position and handshake state
//  a stalled result holds the input register, so intake stops after one more
//  request; config writes are always ready and writes to known registers restart the row
module max_pool_1d_argmax_top import mpa_pkg::*; #(
  parameter int POOL_MAX    = 8,
  parameter int ROW_MAX     = 4096,
  parameter int SAMPLE_BITS = 16,
  localparam int SW = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1
) (
  input  logic     clk,
  input  logic     rst,
  mpa_in_if.sink   in_ch,
  mpa_out_if.source out_ch,
  mpa_cfg_if.sink  cfg_ch
);

  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          advance;
  logic                          out_valid;
  logic                          restart;
  cfg_t                          cfg_eff;
  pos_t                          pos;
  logic [SW-1:0]                 khi_slot;
  logic                          emit;
  logic signed [SAMPLE_BITS-1:0] res_value;
  logic [IDX_W-1:0]              res_position;
  logic [IDX_W-1:0]              res_window;
  logic                          res_last;

  // handshake: the input register moves on whenever the result register is free
  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;
  assign cfg_ch.ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_sample <= in_ch.sample;
    end
  end

  mpa_cfg #(
    .POOL_MAX (POOL_MAX),
    .ROW_MAX  (ROW_MAX)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr       (cfg_ch.valid && cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .eff      (cfg_eff),
    .restart  (restart)
  );

  mpa_pos #(
    .POOL_MAX (POOL_MAX)
  ) u_pos (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .step     (advance),
    .cfg      (cfg_eff),
    .pos      (pos),
    .khi_slot (khi_slot)
  );

  mpa_slots #(
    .POOL_MAX    (POOL_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_slots (
    .clk          (clk),
    .step         (advance),
    .sample       (in_sample),
    .cfg          (cfg_eff),
    .pos          (pos),
    .khi_slot     (khi_slot),
    .emit         (emit),
    .max_value    (res_value),
    .max_position (res_position),
    .window_index (res_window),
    .last_window  (res_last)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_ch.max_value    <= res_value;
      out_ch.max_position <= res_position;
      out_ch.window_index <= res_window;
      out_ch.last_window  <= res_last;
    end
  end

  assign out_ch.valid = out_valid;

  // row position stays inside the row
  a_pos_in_row: assert property (@(posedge clk) disable iff (rst)
    pos.pos < cfg_eff.len)
    else $error("row position beyond row length");

  // phase stays below the stride
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    pos.phase < cfg_eff.stride)
    else $error("stride phase out of range");

  // a stalled result keeps the pending request in the input register
  a_hold_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !out_ch.ready |=> in_valid)
    else $error("request dropped under stall");

  // a closing window always shows up on the result channel
  a_emit_shown: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> out_valid)
    else $error("window result lost");

endmodule
